FILE: sv/bft_pkg.sv
// Shared constants and types for the exhaustive open-path search block.
package bft_pkg;

  localparam int MaxSites   = 8;
  localparam int SiteBits   = 3;
  localparam int WeightBits = 16;
  localparam int LenBits    = 24;
  localparam int OutLenBits = 19;
  localparam logic [LenBits-1:0] LengthStart = 24'd10000000;
  localparam logic [OutLenBits-1:0] OutLenMax = 19'd524287;

  typedef logic [SiteBits-1:0] site_t;
  typedef site_t [MaxSites-1:0] order_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_NEXT,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // write weight entry
    logic init;      // reset orders and best length
    logic step;      // walk one pair of the current order
    logic eval;      // compare finished sum with best
    logic advance;   // step to next permutation
    logic emit_clr;  // reset output pointer
    logic emit_adv;  // output item taken
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic more;      // a further permutation exists
    logic sum_done;  // path sum of current order complete
    logic emit_last; // pointer at final site
  } dp_stat_t;

endpackage

FILE: sv/brute_force_open_tour_search.sv
// Top level of the exhaustive open-path search block.
// Usage:
//  Input channel (in_valid/in_stall) carries cmd, from_site, to_site, weight.
//  cmd 0 loads one weight entry and gives no result; loads
//  can follow back to back while idle.
//  cmd 1 starts a search over all orderings of sites 1..n-1, site 0 first.
//  Each ordering takes n-1 weight reads, one per cycle from the memory
//  port, then adds the last read, sees the sum done, and compares and
//  steps the permutation. The whole sweep runs before the first item
//  goes out, and its length is set by the single memory read port.
//  Then n items go out on (out_valid/out_stall): site_index, tour_length
//  and last on the final site; one item per cycle unless stalled.
//  A stall on the output holds the current item; no input is taken
//  until the last item is delivered.
//  The user writes node_count (cfg_we/cfg_data) only while idle; the block
//  does not enforce this. 0 reads as 1, above 8 saturates to 8. Reset sets
//  node_count to 8 and idles the block. Weights are undefined until loaded.
module brute_force_open_tour_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [2:0]  from_site,
  input  logic [2:0]  to_site,
  input  logic [15:0] weight,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  site_index,
  output logic [18:0] tour_length,
  output logic        last
);

  logic [3:0] node_count;
  logic [3:0] n_sites;
  bft_pkg::dp_cmd_t  dcmd;
  bft_pkg::dp_stat_t dstat;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) node_count <= 4'd8;
    else if (cfg_we) node_count <= cfg_data;
  end

  always_comb begin
    if (node_count == 4'd0) n_sites = 4'd1;
    else if (node_count > 4'(bft_pkg::MaxSites)) n_sites = 4'(bft_pkg::MaxSites);
    else n_sites = node_count;
  end

  bft_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd_start(cmd), .out_valid(out_valid), .out_stall(out_stall),
    .cmd(dcmd), .stat(dstat)
  );

  bft_datapath u_dp (
    .clk(clk), .cmd(dcmd), .stat(dstat), .n_sites(n_sites),
    .from_site(from_site), .to_site(to_site), .weight(weight),
    .out_site(site_index), .out_len(tour_length)
  );

  assign last = dstat.emit_last;

endmodule

FILE: sv/bft_datapath.sv
// Datapath: weight memory, permutation register, path sum and best tracking.
module bft_datapath (
  input  logic                            clk,
  input  bft_pkg::dp_cmd_t                cmd,
  output bft_pkg::dp_stat_t               stat,
  input  logic [3:0]                      n_sites,
  input  logic [bft_pkg::SiteBits-1:0]    from_site,
  input  logic [bft_pkg::SiteBits-1:0]    to_site,
  input  logic [bft_pkg::WeightBits-1:0]  weight,
  output logic [bft_pkg::SiteBits-1:0]    out_site,
  output logic [bft_pkg::OutLenBits-1:0]  out_len
);

  // Weight memory: written by load items, one registered read a cycle
  logic [bft_pkg::WeightBits-1:0] wt [bft_pkg::MaxSites*bft_pkg::MaxSites];
  bft_pkg::order_t cur;
  bft_pkg::order_t best;
  logic [bft_pkg::LenBits-1:0] best_len;
  logic [bft_pkg::SiteBits-1:0] emit_ptr;

  // Pair walk state: read issued at pos, summed in the following cycle
  logic [bft_pkg::WeightBits-1:0] rd_data;
  logic [bft_pkg::SiteBits-1:0] pos;
  logic pend;
  logic [bft_pkg::LenBits-1:0] acc;
  logic issue;

  assign issue = ({1'b0, pos} + 4'd1) < n_sites;

  always_ff @(posedge clk) begin
    if (cmd.load) wt[{from_site, to_site}] <= weight;
    if (cmd.step && issue) rd_data <= wt[{cur[pos], cur[pos + 3'd1]}];
  end

  // Accumulate the open path sum, one pair per cycle
  always_ff @(posedge clk) begin
    if (cmd.init || cmd.advance) begin
      pos  <= '0;
      pend <= 1'b0;
      acc  <= '0;
    end else if (cmd.step) begin
      pend <= issue;
      if (issue) pos <= pos + 3'd1;
      if (pend) acc <= acc + bft_pkg::LenBits'(rd_data);
    end
  end

  // Next lexicographic permutation of positions 1..n-1
  bft_pkg::order_t nxt;
  logic more;
  logic [3:0] piv;
  logic [3:0] swp;
  logic [3:0] last;
  always_comb begin
    last = n_sites - 4'd1;
    piv = '0;
    swp = '0;
    for (int i = 2; i < bft_pkg::MaxSites; i++) begin
      if (4'(i) <= last && cur[i-1] < cur[i]) piv = 4'(i);
    end
    more = (n_sites >= 4'd3) && (piv != 4'd0);
    for (int j = 1; j < bft_pkg::MaxSites; j++) begin
      if (piv != 4'd0 && 4'(j) >= piv && 4'(j) <= last
          && cur[j] > cur[piv[2:0]-3'd1]) swp = 4'(j);
    end
    nxt = cur;
    if (more) begin
      nxt[piv[2:0]-3'd1] = cur[swp[2:0]];
      nxt[swp[2:0]] = cur[piv[2:0]-3'd1];
    end
    // reverse the tail; pivot 1 when done reverses 1..n-1 to sorted
    for (int k = 1; k < bft_pkg::MaxSites; k++) begin
      logic [3:0] lo;
      logic [4:0] mir;
      lo = more ? piv : 4'd1;
      mir = 5'(lo) + 5'(last) - 5'(k);
      if (4'(k) >= lo && 4'(k) <= last && n_sites >= 4'd3) begin
        if (more && mir[2:0] == swp[2:0]) nxt[k] = cur[piv[2:0]-3'd1];
        else nxt[k] = cur[mir[2:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      for (int i = 0; i < bft_pkg::MaxSites; i++) begin
        cur[i]  <= bft_pkg::SiteBits'(i);
        best[i] <= bft_pkg::SiteBits'(i);
      end
      best_len <= bft_pkg::LengthStart;
    end else begin
      if (cmd.eval && acc < best_len) begin
        best_len <= acc;
        best <= cur;
      end
      if (cmd.advance) cur <= nxt;
    end
    if (cmd.emit_clr) emit_ptr <= '0;
    else if (cmd.emit_adv) emit_ptr <= emit_ptr + 3'd1;
  end

  assign out_site = best[emit_ptr];
  assign out_len = (best_len > bft_pkg::LenBits'(bft_pkg::OutLenMax)) ?
                   bft_pkg::OutLenMax : best_len[bft_pkg::OutLenBits-1:0];
  assign stat.more = more;
  assign stat.sum_done = !issue && !pend;
  assign stat.emit_last = ({1'b0, emit_ptr} == n_sites - 4'd1);

endmodule

FILE: sv/bft_ctrl.sv
// Controller: sequences load, permutation sweep and result output.
module bft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd_start,
  output logic              out_valid,
  input  logic              out_stall,
  output bft_pkg::dp_cmd_t  cmd,
  input  bft_pkg::dp_stat_t stat
);

  bft_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bft_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      bft_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (cmd_start) begin
            cmd.init = 1'b1;
            state_next = bft_pkg::ST_EVAL;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      bft_pkg::ST_EVAL: begin
        cmd.step = 1'b1;
        if (stat.sum_done) state_next = bft_pkg::ST_NEXT;
      end
      bft_pkg::ST_NEXT: begin
        cmd.eval = 1'b1;
        cmd.advance = 1'b1;
        if (!stat.more) begin
          cmd.emit_clr = 1'b1;
          state_next = bft_pkg::ST_EMIT;
        end else begin
          state_next = bft_pkg::ST_EVAL;
        end
      end
      bft_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_adv = 1'b1;
          if (stat.emit_last) state_next = bft_pkg::ST_IDLE;
        end
      end
      default: state_next = bft_pkg::ST_IDLE;
    endcase
  end

  // Input is only taken when idle
  assert property (@(posedge clk) disable iff (rst)
    (state != bft_pkg::ST_IDLE) |-> in_stall) else $error("input taken while busy");
  // Output valid only in emit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == bft_pkg::ST_EMIT) else $error("stray output");
  // A start leads to the sweep
  assert property (@(posedge clk) disable iff (rst)
    (cmd.init) |=> state == bft_pkg::ST_EVAL) else $error("start lost");

endmodule
